FILE: rtl/eeprom_bit_serial_command_engine_core_defines.svh
// Assertion macros shared by the engine RTL.
`ifndef EEPROM_BIT_SERIAL_COMMAND_ENGINE_CORE_DEFINES_SVH
`define EEPROM_BIT_SERIAL_COMMAND_ENGINE_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EEBSCE_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define EEBSCE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/eebsce_pkg.sv
package eebsce_pkg;

  localparam int SLOT_W      = 7;
  localparam int TICK_W      = 10;
  localparam int ADDR_W      = 14;
  localparam int WDATA_W     = 64;
  localparam int RDATA_W     = 64;
  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 72;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [TICK_W-1:0] TIMEOUT_RESET = 10'd10;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_SLOT  = 2'd2,
    OP_TICK  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_TIMEOUT = 2'd1,
    ST_IGNORED = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_CMD    = 3'd1,
    PH_SAMPLE = 3'd2,
    PH_POLL   = 3'd3
  } phase_t;

  localparam logic CFG_LARGE_ADDRESS = 1'b0;
  localparam logic CFG_TIMEOUT_TICKS = 1'b1;

endpackage

FILE: rtl/eeprom_bit_serial_command_engine_core.sv
// A result reaches the output register in the cycle after its item is accepted.
// Throughput: one item per cycle; a single state update stands between input and result.
// A new item enters when the result register is empty or its result is taken that cycle.
// Reset (synchronous, active low) returns the engine to idle with all counters cleared,
// large_address to 0 and timeout_ticks to 10.
`include "eeprom_bit_serial_command_engine_core_defines.svh"

module eeprom_bit_serial_command_engine_core #(
  parameter int DATA_BITS       = 64,
  parameter int SHORT_ADDR_BITS = 6,
  parameter int LONG_ADDR_BITS  = 14,
  parameter int SKIP_BITS       = 4
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // blk_index[13:0], write_data[77:14], in_bit[78], zero pad[79]
  input  logic [eebsce_pkg::IN_TDATA_W-1:0]     in_tdata,
  // op[1:0]
  input  logic [1:0]                            in_tuser,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // drive_bit[0], drive_enable[1], read_data[65:2], zero pad[71:66]
  output logic [eebsce_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // status[1:0]
  output logic [1:0]                            out_tuser,
  // done_res
  output logic                                  out_tlast,
  input  logic                                  cfg_psel,
  input  logic                                  cfg_penable,
  input  logic                                  cfg_pwrite,
  input  logic [eebsce_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [eebsce_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [eebsce_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                  cfg_pready
);
  import eebsce_pkg::*;

  localparam logic [SLOT_W-1:0] SHORT_LEN  = SLOT_W'(SHORT_ADDR_BITS);
  localparam logic [SLOT_W-1:0] LONG_LEN   = SLOT_W'(LONG_ADDR_BITS);
  localparam logic [SLOT_W-1:0] DATA_LEN   = SLOT_W'(DATA_BITS);
  localparam logic [SLOT_W-1:0] SKIP_LEN   = SLOT_W'(SKIP_BITS);
  localparam logic [SLOT_W-1:0] SAMPLE_END = SLOT_W'(SKIP_BITS + DATA_BITS);
  localparam logic [SLOT_W-1:0] HDR_LEN    = SLOT_W'(2);

  logic                  large_r;
  logic [TICK_W-1:0]     timeout_r;

  phase_t                phase_r, phase_nxt;
  logic [SLOT_W-1:0]     slot_r, slot_nxt;
  logic [ADDR_W-1:0]     addr_r, addr_nxt;
  logic [DATA_BITS-1:0]  shift_r, shift_nxt;
  logic                  is_write_r, is_write_nxt;
  logic [TICK_W-1:0]     tick_r, tick_nxt;

  logic                  out_valid_r;
  logic                  dbit_r, dbit_nxt;
  logic                  den_r, den_nxt;
  logic [RDATA_W-1:0]    rdata_r, rdata_nxt;
  logic                  done_r, done_nxt;
  status_t               status_r, status_nxt;

  logic                  in_fire;
  logic                  cfg_write;
  op_t                   in_op;
  logic [ADDR_W-1:0]     in_addr;
  logic [WDATA_W-1:0]    in_wdata;
  logic                  in_bit;

  logic [SLOT_W-1:0]     addr_len;
  logic [SLOT_W-1:0]     addr_end;
  logic [SLOT_W-1:0]     data_end;
  logic [SLOT_W-1:0]     addr_sh;
  logic [SLOT_W-1:0]     data_sh;
  logic [ADDR_W-1:0]     addr_shifted;
  logic [DATA_BITS-1:0]  data_shifted;
  logic [SLOT_W-1:0]     slot_inc;
  logic [TICK_W-1:0]     tick_inc;
  logic                  start_ok;
  logic                  cmd_end;
  logic                  sample_end;
  logic                  poll_hit;
  logic                  poll_timeout;

  assign in_fire   = in_tvalid && in_tready;
  assign in_tready = !out_valid_r || out_tready;
  assign in_op     = op_t'(in_tuser);
  assign in_addr   = in_tdata[ADDR_W-1:0];
  assign in_wdata  = in_tdata[ADDR_W +: WDATA_W];
  assign in_bit    = in_tdata[ADDR_W+WDATA_W];

  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    case (cfg_paddr[2])
      CFG_LARGE_ADDRESS: cfg_prdata = {{(CFG_DATA_W-1){1'b0}}, large_r};
      default:           cfg_prdata = {{(CFG_DATA_W-TICK_W){1'b0}}, timeout_r};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      large_r   <= 1'b0;
      timeout_r <= TIMEOUT_RESET;
    end else if (cfg_write) begin
      case (cfg_paddr[2])
        CFG_LARGE_ADDRESS: large_r   <= cfg_pwdata[0];
        default:           timeout_r <= cfg_pwdata[TICK_W-1:0];
      endcase
    end
  end

  assign addr_len     = large_r ? LONG_LEN : SHORT_LEN;
  assign addr_end     = HDR_LEN + addr_len;
  assign data_end     = addr_end + DATA_LEN;
  assign addr_sh      = addr_end - SLOT_W'(1) - slot_r;
  assign data_sh      = data_end - SLOT_W'(1) - slot_r;
  assign addr_shifted = addr_r >> addr_sh;
  assign data_shifted = shift_r >> data_sh;
  assign slot_inc     = slot_r + SLOT_W'(1);
  assign tick_inc     = tick_r + TICK_W'(1);

  assign start_ok     = (in_op == OP_READ || in_op == OP_WRITE) && phase_r == PH_IDLE;
  assign cmd_end      = in_op == OP_SLOT && phase_r == PH_CMD && slot_r >= HDR_LEN
                        && slot_r >= addr_end && (!is_write_r || slot_r >= data_end);
  assign sample_end   = in_op == OP_SLOT && phase_r == PH_SAMPLE && slot_inc >= SAMPLE_END;
  assign poll_hit     = in_op == OP_SLOT && phase_r == PH_POLL && in_bit;
  assign poll_timeout = in_op == OP_TICK && phase_r == PH_POLL && tick_inc >= timeout_r;

  always_comb begin
    phase_nxt = phase_r;
    if (start_ok) begin
      phase_nxt = PH_CMD;
    end else if (cmd_end) begin
      phase_nxt = is_write_r ? PH_POLL : PH_SAMPLE;
    end else if (sample_end || poll_hit || poll_timeout) begin
      phase_nxt = PH_IDLE;
    end
  end

  always_comb begin
    slot_nxt     = slot_r;
    addr_nxt     = addr_r;
    shift_nxt    = shift_r;
    is_write_nxt = is_write_r;
    tick_nxt     = tick_r;
    dbit_nxt     = 1'b0;
    den_nxt      = 1'b0;
    rdata_nxt    = '0;
    done_nxt     = 1'b0;
    status_nxt   = ST_OK;
    case (in_op)
      OP_READ, OP_WRITE: begin
        if (start_ok) begin
          addr_nxt     = in_addr;
          is_write_nxt = (in_op == OP_WRITE);
          shift_nxt    = (in_op == OP_WRITE) ? in_wdata[DATA_BITS-1:0] : '0;
          slot_nxt     = '0;
          tick_nxt     = '0;
        end else begin
          status_nxt = ST_IGNORED;
        end
      end
      OP_SLOT: begin
        case (phase_r)
          PH_CMD: begin
            den_nxt = 1'b1;
            if (slot_r < HDR_LEN) begin
              dbit_nxt = (slot_r == '0) ? 1'b1 : !is_write_r;
              slot_nxt = slot_inc;
            end else if (slot_r < addr_end) begin
              dbit_nxt = addr_shifted[0];
              slot_nxt = slot_inc;
            end else if (is_write_r && slot_r < data_end) begin
              dbit_nxt = data_shifted[0];
              slot_nxt = slot_inc;
            end else begin
              slot_nxt = '0;
              tick_nxt = '0;
              if (!is_write_r) begin
                shift_nxt = '0;
              end
            end
          end
          PH_SAMPLE: begin
            if (slot_r >= SKIP_LEN) begin
              shift_nxt = {shift_r[DATA_BITS-2:0], in_bit};
            end
            slot_nxt = slot_inc;
            if (sample_end) begin
              rdata_nxt = RDATA_W'(shift_nxt);
              done_nxt  = 1'b1;
              slot_nxt  = '0;
            end
          end
          PH_POLL: begin
            done_nxt = in_bit;
          end
          default: begin
            status_nxt = ST_IGNORED;
          end
        endcase
      end
      default: begin
        if (phase_r == PH_POLL) begin
          tick_nxt = tick_inc;
          if (poll_timeout) begin
            done_nxt   = 1'b1;
            status_nxt = ST_TIMEOUT;
          end
        end else begin
          status_nxt = ST_IGNORED;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      slot_r     <= '0;
      addr_r     <= '0;
      shift_r    <= '0;
      is_write_r <= 1'b0;
      tick_r     <= '0;
    end else if (in_fire) begin
      phase_r    <= phase_nxt;
      slot_r     <= slot_nxt;
      addr_r     <= addr_nxt;
      shift_r    <= shift_nxt;
      is_write_r <= is_write_nxt;
      tick_r     <= tick_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_tready) begin
      out_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      dbit_r   <= dbit_nxt;
      den_r    <= den_nxt;
      rdata_r  <= rdata_nxt;
      done_r   <= done_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-RDATA_W-2){1'b0}}, rdata_r, den_r, dbit_r};
  assign out_tuser  = status_r;
  assign out_tlast  = done_r;

  `EEBSCE_ASSERT_SAME(a_idle_slot_clear, phase_r == PH_IDLE, slot_r == '0, "idle with nonzero slot count")
  `EEBSCE_ASSERT_SAME(a_sample_in_range, phase_r == PH_SAMPLE, slot_r < SAMPLE_END, "sample slot count past end")
  `EEBSCE_ASSERT_NEXT(a_done_to_idle, in_fire && done_nxt, phase_r == PH_IDLE, "finished item did not return to idle")
  `EEBSCE_ASSERT_SAME(a_drive_not_done, out_valid_r && den_r, !done_r && status_r == ST_OK, "driven slot marked done or not ok")
  `EEBSCE_ASSERT_NEXT(a_idle_slot_ignored, in_fire && in_op == OP_SLOT && phase_r == PH_IDLE, status_r == ST_IGNORED, "bit slot while idle not ignored")

endmodule

FILE: dv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import eebsce_pkg::*;

  localparam int unsigned WORD_BITS      = 64;
  localparam int unsigned NARROW_ADDR    = 6;
  localparam int unsigned WIDE_ADDR      = 14;
  localparam int unsigned LEAD_SAMPLES   = 4;
  localparam int unsigned N_SEG          = 7;
  localparam int unsigned SEG_ITEMS      = 205;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned HOLD_CYCLES    = 300;

  typedef struct packed {
    op_t         op;
    logic [13:0] blk;
    logic [63:0] wdat;
    logic        ibit;
  } req_t;

  typedef struct packed {
    logic        dbit;
    logic        den;
    logic [63:0] rdat;
    logic        done;
    status_t     st;
  } rsp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic [1:0] in_tuser = OP_READ;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [1:0] out_tuser;
  logic out_tlast;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic cfg_pready;

  eeprom_bit_serial_command_engine_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #10 clk = ~clk;

  // Engine state as the checker sees it.
  logic        eng_large = 1'b0;
  logic [9:0]  eng_tmo = TIMEOUT_RESET;
  phase_t      eng_ph = PH_IDLE;
  logic [6:0]  eng_slot = '0;
  logic [13:0] eng_addr = '0;
  logic [63:0] eng_shift = '0;
  logic        eng_wr = 1'b0;
  logic [9:0]  eng_ticks = '0;

  req_t pending[$];
  req_t txn_q[$];
  rsp_t exp_q[$];
  req_t on_bus;
  rsp_t want;
  int unsigned n_queued = 0;
  int unsigned n_accepted = 0;
  int unsigned n_errors = 0;
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;
  int unsigned hold_left = 0;
  int unsigned holds_done = 0;
  int unsigned hold_mark = 250;
  int unsigned taken = 0;
  int unsigned rx_mode = 0;
  int unsigned mode_left = 0;
  int unsigned stall_cycles = 0;

  function automatic rsp_t engine_step(input req_t r);
    rsp_t o;
    int unsigned na;
    int unsigned k;
    o = '{dbit: 1'b0, den: 1'b0, rdat: '0, done: 1'b0, st: ST_OK};
    na = eng_large ? WIDE_ADDR : NARROW_ADDR;
    case (r.op)
      OP_READ, OP_WRITE: begin
        if (eng_ph != PH_IDLE) begin
          o.st = ST_IGNORED;
        end else begin
          eng_addr = r.blk;
          eng_wr = (r.op == OP_WRITE);
          eng_shift = eng_wr ? r.wdat : '0;
          eng_slot = '0;
          eng_ticks = '0;
          eng_ph = PH_CMD;
        end
      end
      OP_SLOT: begin
        case (eng_ph)
          PH_CMD: begin
            o.den = 1'b1;
            k = eng_slot;
            if (k < 2) begin
              o.dbit = (k == 0) ? 1'b1 : !eng_wr;
            end else if (k < 2 + na) begin
              o.dbit = eng_addr[na - 1 - (k - 2)];
            end else if (eng_wr && k < 2 + na + WORD_BITS) begin
              o.dbit = eng_shift[WORD_BITS - 1 - (k - 2 - na)];
            end else begin
              o.dbit = 1'b0;
              eng_slot = '0;
              eng_ticks = '0;
              if (!eng_wr) eng_shift = '0;
              eng_ph = eng_wr ? PH_POLL : PH_SAMPLE;
            end
            if (eng_ph == PH_CMD) eng_slot = eng_slot + 7'd1;
          end
          PH_SAMPLE: begin
            if (eng_slot >= LEAD_SAMPLES) eng_shift = {eng_shift[62:0], r.ibit};
            eng_slot = eng_slot + 7'd1;
            if (eng_slot >= LEAD_SAMPLES + WORD_BITS) begin
              o.rdat = eng_shift;
              o.done = 1'b1;
              eng_slot = '0;
              eng_ph = PH_IDLE;
            end
          end
          PH_POLL: begin
            if (r.ibit) begin
              o.done = 1'b1;
              eng_ph = PH_IDLE;
            end
          end
          default: o.st = ST_IGNORED;
        endcase
      end
      default: begin
        if (eng_ph == PH_POLL) begin
          eng_ticks = eng_ticks + 10'd1;
          if (eng_ticks >= eng_tmo) begin
            o.done = 1'b1;
            o.st = ST_TIMEOUT;
            eng_ph = PH_IDLE;
          end
        end else begin
          o.st = ST_IGNORED;
        end
      end
    endcase
    return o;
  endfunction

  function automatic void check_field(input string what, input logic [63:0] exp_v,
                                      input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, exp_v, act_v);
      n_errors++;
    end
  endfunction

  function automatic req_t mk(input op_t op, input logic [13:0] blk, input logic [63:0] wd,
                              input logic ib);
    req_t r;
    r.op = op;
    r.blk = blk;
    r.wdat = wd;
    r.ibit = ib;
    return r;
  endfunction

  function automatic logic [63:0] pick64();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [13:0] pick_blk();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return 14'($urandom);
    endcase
  endfunction

  task automatic push_item(input req_t r);
    pending.push_back(r);
    n_queued++;
  endtask

  // One read or write with random content, occasionally cut short or mixed with stray items.
  task automatic plan_transfer();
    req_t t[$];
    int unsigned na;
    int unsigned n;
    int unsigned cut;
    int unsigned i;
    na = eng_large ? WIDE_ADDR : NARROW_ADDR;
    if ($urandom_range(0, 1) == 0) begin
      t.push_back(mk(OP_READ, pick_blk(), pick64(), 1'($urandom)));
      for (i = 0; i < 2 + na + 1 + LEAD_SAMPLES + WORD_BITS; i++)
        t.push_back(mk(OP_SLOT, 14'($urandom), {$urandom, $urandom}, 1'($urandom)));
    end else begin
      t.push_back(mk(OP_WRITE, pick_blk(), pick64(), 1'($urandom)));
      for (i = 0; i < 2 + na + WORD_BITS + 1; i++)
        t.push_back(mk(OP_SLOT, 14'($urandom), {$urandom, $urandom}, 1'($urandom)));
      if (eng_tmo <= 40 && $urandom_range(0, 1) == 0) begin
        n = (eng_tmo == 0) ? 1 : eng_tmo;
        for (i = 0; i < n; i++) begin
          if ($urandom_range(0, 2) == 0) t.push_back(mk(OP_SLOT, pick_blk(), pick64(), 1'b0));
          t.push_back(mk(OP_TICK, pick_blk(), pick64(), 1'($urandom)));
        end
      end else begin
        n = (eng_tmo > 1) ? $urandom_range(0, (eng_tmo - 1 < 4) ? eng_tmo - 1 : 4) : 0;
        for (i = 0; i < n; i++) t.push_back(mk(OP_TICK, pick_blk(), pick64(), 1'($urandom)));
        n = $urandom_range(0, 5);
        for (i = 0; i < n; i++) t.push_back(mk(OP_SLOT, pick_blk(), pick64(), 1'b0));
        t.push_back(mk(OP_SLOT, pick_blk(), pick64(), 1'b1));
      end
    end
    cut = ($urandom_range(0, 11) == 0) ? $urandom_range(1, t.size()) : t.size();
    for (i = 0; i < cut; i++) begin
      if ($urandom_range(0, 19) == 0)
        txn_q.push_back(mk(op_t'($urandom_range(0, 3)), 14'($urandom), pick64(),
                           1'($urandom)));
      txn_q.push_back(t[i]);
    end
  endtask

  task automatic drain();
    while (n_accepted != n_queued || exp_q.size() != 0) @(posedge clk);
  endtask

  task automatic apb_xfer(input logic wr, input logic [CFG_ADDR_W-1:0] a,
                          input logic [31:0] wd, output logic [31:0] rd);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= wr;
    cfg_paddr <= a;
    cfg_pwdata <= wd;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rd = cfg_prdata;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_regs(input logic wide_addr, input logic [9:0] tmo);
    logic [31:0] rd;
    logic [CFG_ADDR_W-1:0] a_large;
    logic [CFG_ADDR_W-1:0] a_tmo;
    a_large = {CFG_LARGE_ADDRESS, 2'b00};
    a_tmo = {CFG_TIMEOUT_TICKS, 2'b00};
    apb_xfer(1'b1, a_large, {31'd0, wide_addr}, rd);
    eng_large = wide_addr;
    apb_xfer(1'b1, a_tmo, {22'd0, tmo}, rd);
    eng_tmo = tmo;
    apb_xfer(1'b0, a_large, '0, rd);
    check_field("large_address readback", {63'd0, wide_addr}, {32'd0, rd});
    apb_xfer(1'b0, a_tmo, '0, rd);
    check_field("timeout_ticks readback", {54'd0, tmo}, {32'd0, rd});
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        exp_q.push_back(engine_step(on_bus));
        n_accepted++;
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (pending.size() > 0) begin
          on_bus = pending.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {1'b0, on_bus.ibit, on_bus.wdat, on_bus.blk};
          in_tuser <= on_bus.op;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 60);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) taken++;
      if (hold_left == 0 && holds_done < 3 && taken >= hold_mark && pending.size() > 100) begin
        hold_left = HOLD_CYCLES;
        holds_done++;
        hold_mark = taken + 600;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        case (rx_mode)
          0: out_tready <= 1'b1;
          1: out_tready <= ($urandom_range(0, 3) != 0);
          2: out_tready <= ($urandom_range(0, 1) != 0);
          default: out_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (exp_q.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, actual %0h status %0h done %0b",
                 $time, out_tdata, out_tuser, out_tlast);
        n_errors++;
      end else begin
        want = exp_q.pop_front();
        check_field("drive_bit", {63'd0, want.dbit}, {63'd0, out_tdata[0]});
        check_field("drive_enable", {63'd0, want.den}, {63'd0, out_tdata[1]});
        check_field("read_data", want.rdat, out_tdata[65:2]);
        check_field("done", {63'd0, want.done}, {63'd0, out_tlast});
        check_field("status", {62'd0, want.st}, {62'd0, out_tuser});
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel)
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles == WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int unsigned seg;
    int unsigned k;
    logic seg_large[N_SEG];
    logic [9:0] seg_tmo[N_SEG];
    seg_large = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
    seg_tmo = '{10'd10, 10'd1023, 10'd1, 10'd0, 10'd7, 10'd40, 10'd1023};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Ignored items, starts while busy, and a read to the highest block address.
    push_item(mk(OP_SLOT, '0, '0, 1'b1));
    push_item(mk(OP_TICK, '1, '1, 1'b0));
    push_item(mk(OP_READ, '1, '1, 1'b1));
    push_item(mk(OP_WRITE, '0, '1, 1'b0));
    push_item(mk(OP_READ, '0, '0, 1'b0));
    push_item(mk(OP_TICK, '0, '0, 1'b1));
    for (k = 0; k < 2 + NARROW_ADDR + 1; k++) push_item(mk(OP_SLOT, '0, '0, k[0]));
    push_item(mk(OP_TICK, '1, '0, 1'b0));

    for (seg = 0; seg < N_SEG; seg++) begin
      if (seg > 0) begin
        drain();
        set_regs(seg_large[seg], seg_tmo[seg]);
      end
      for (k = 0; k < SEG_ITEMS; k++) begin
        if (txn_q.size() == 0) plan_transfer();
        push_item(txn_q.pop_front());
      end
    end

    drain();
    repeat (6) @(posedge clk);
    if (n_errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
